FILE: rtl/ssc_pkg.sv
// Shared types and constants for the sphere-sphere contact core.
package ssc_pkg;

	// Radicand, root and remainder widths of the square root pipeline
	localparam int SQ_W   = 66;
	localparam int ROOT_W = 33;
	localparam int REM_W  = 35;
	// Quotient width of the normal divider (magnitude never exceeds 2^30)
	localparam int Q_W    = 31;
	localparam int MAG_W  = 32;
	localparam int AXES   = 3;

	typedef struct packed {
		logic signed [31:0] center_a_x;
		logic signed [31:0] center_a_y;
		logic signed [31:0] center_a_z;
		logic [30:0]        radius_a;
		logic signed [31:0] center_b_x;
		logic signed [31:0] center_b_y;
		logic signed [31:0] center_b_z;
		logic [30:0]        radius_b;
	} in_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] normal_x;
		logic signed [31:0] normal_y;
		logic signed [31:0] normal_z;
		logic signed [31:0] contact_x;
		logic signed [31:0] contact_y;
		logic signed [31:0] contact_z;
		logic [31:0]        penetration;
	} out_t;

	// Data that rides alongside the square root
	typedef struct packed {
		logic [AXES-1:0]             neg;
		logic [AXES-1:0][MAG_W-1:0]  mag;
		logic [AXES-1:0][31:0]       contact;
		logic [31:0]                 rsum;
	} side_t;

	// Data that rides alongside the divider
	typedef struct packed {
		logic                        hit;
		logic [31:0]                 len;
		logic [AXES-1:0]             neg;
		logic [AXES-1:0][31:0]       contact;
		logic [31:0]                 pen;
	} hit_t;

endpackage

FILE: rtl/sphere_sphere_contact_core.sv
// Sphere-sphere contact core: accepts one sphere pair per clock and returns
// hit, unit normal (Q1.30), contact point (Q16.16) and penetration. The
// pipeline is a four-stage front end (difference, magnitude and contact,
// squares, sum), a 33-stage square root that retires one root bit per stage,
// one hit-decision stage, a 31-stage divider that retires one quotient bit
// per stage for all three axes, and the output register. The whole pipeline
// advances together; it holds only while a finished result waits at the
// output, so a steady stream moves one pair per cycle whenever the consumer
// takes one per cycle.
module sphere_sphere_contact_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  ssc_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output ssc_pkg::out_t out_data
);

	logic                                         en;
	logic                                         fe_valid;
	logic [ssc_pkg::SQ_W-1:0]                     fe_sq;
	ssc_pkg::side_t                               fe_side;
	logic                                         rt_valid;
	logic [ssc_pkg::ROOT_W-1:0]                   rt_root;
	ssc_pkg::side_t                               rt_side;
	logic                                         v_s1;
	logic [ssc_pkg::AXES-1:0][ssc_pkg::MAG_W-1:0] mag_s1;
	ssc_pkg::hit_t                                info_s1;
	logic                                         dv_valid;
	logic [ssc_pkg::AXES-1:0][ssc_pkg::Q_W-1:0]   dv_quo;
	ssc_pkg::hit_t                                dv_info;
	logic                                         out_valid_q;
	ssc_pkg::out_t                                out_q;
	logic [ssc_pkg::AXES-1:0][31:0]               nrm;

	// Advance the pipeline unless a result waits untaken
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	ssc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.in_data   (in_data),
		.out_valid (fe_valid),
		.sq        (fe_sq),
		.side      (fe_side)
	);

	ssc_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fe_valid),
		.rad       (fe_sq),
		.side_in   (fe_side),
		.out_valid (rt_valid),
		.root      (rt_root),
		.side_out  (rt_side)
	);

	// Decide hit: nonzero length not above the radius sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= rt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1          <= rt_side.mag;
			info_s1.hit     <= (rt_root != '0) && ({1'b0, rt_side.rsum} >= rt_root);
			info_s1.len     <= rt_root[31:0];
			info_s1.neg     <= rt_side.neg;
			info_s1.contact <= rt_side.contact;
			info_s1.pen     <= rt_side.rsum - rt_root[31:0];
		end
	end

	ssc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s1),
		.mag       (mag_s1),
		.info_in   (info_s1),
		.out_valid (dv_valid),
		.quo       (dv_quo),
		.info_out  (dv_info)
	);

	// Apply signs to the normal
	always_comb begin
		for (int l = 0; l < ssc_pkg::AXES; l++) begin
			nrm[l] = dv_info.neg[l] ? 32'(-{1'b0, dv_quo[l]}) : 32'({1'b0, dv_quo[l]});
		end
	end

	// Output register; zero everything on a miss
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q.hit <= dv_info.hit;
			if (dv_info.hit) begin
				out_q.normal_x    <= nrm[0];
				out_q.normal_y    <= nrm[1];
				out_q.normal_z    <= nrm[2];
				out_q.contact_x   <= dv_info.contact[0];
				out_q.contact_y   <= dv_info.contact[1];
				out_q.contact_z   <= dv_info.contact[2];
				out_q.penetration <= dv_info.pen;
			end else begin
				out_q.normal_x    <= '0;
				out_q.normal_y    <= '0;
				out_q.normal_z    <= '0;
				out_q.contact_x   <= '0;
				out_q.contact_y   <= '0;
				out_q.contact_z   <= '0;
				out_q.penetration <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Input stalls only behind an untaken result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled without output backpressure");

	// A held result keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("held result changed");

	// A miss carries all-zero fields
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.hit |-> (out_data.normal_x == 0 && out_data.normal_y == 0
			&& out_data.normal_z == 0 && out_data.contact_x == 0
			&& out_data.contact_y == 0 && out_data.contact_z == 0
			&& out_data.penetration == 0))
		else $error("miss with nonzero fields");

	// Normal components stay within unit magnitude
	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.hit |-> (out_data.normal_x <= 32'sd1073741824
			&& out_data.normal_x >= -32'sd1073741824
			&& out_data.normal_y <= 32'sd1073741824
			&& out_data.normal_y >= -32'sd1073741824
			&& out_data.normal_z <= 32'sd1073741824
			&& out_data.normal_z >= -32'sd1073741824))
		else $error("normal component out of range");

endmodule

FILE: rtl/ssc_front.sv
// Front end: center difference, magnitudes, contact point, squared distance.
module ssc_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  ssc_pkg::in_t                in_data,
	output logic                        out_valid,
	output logic [ssc_pkg::SQ_W-1:0]    sq,
	output ssc_pkg::side_t              side
);

	logic signed [31:0] a_c [ssc_pkg::AXES];
	logic signed [31:0] b_c [ssc_pkg::AXES];

	logic               v_s1, v_s2, v_s3, v_s4;
	logic [32:0]        d_s1 [ssc_pkg::AXES];
	logic [31:0]        a_s1 [ssc_pkg::AXES];
	logic [31:0]        rsum_s1;
	ssc_pkg::side_t     side_s2, side_s3, side_s4;
	logic [63:0]        sq_s3 [ssc_pkg::AXES];
	logic [ssc_pkg::SQ_W-1:0] sq_s4;

	logic [32:0]        dabs [ssc_pkg::AXES];
	logic [33:0]        csum [ssc_pkg::AXES];
	logic [31:0]        csat [ssc_pkg::AXES];

	assign a_c[0] = in_data.center_a_x;
	assign a_c[1] = in_data.center_a_y;
	assign a_c[2] = in_data.center_a_z;
	assign b_c[0] = in_data.center_b_x;
	assign b_c[1] = in_data.center_b_y;
	assign b_c[2] = in_data.center_b_z;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Stage 1: difference A - B and radius sum
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < ssc_pkg::AXES; l++) begin
				d_s1[l] <= {a_c[l][31], a_c[l]} - {b_c[l][31], b_c[l]};
				a_s1[l] <= a_c[l];
			end
			rsum_s1 <= 32'(in_data.radius_a) + 32'(in_data.radius_b);
		end
	end

	// Stage 2 logic: magnitude, sign, saturated contact A + floor(d/2)
	always_comb begin
		for (int l = 0; l < ssc_pkg::AXES; l++) begin
			dabs[l] = d_s1[l][32] ? 33'(-d_s1[l]) : d_s1[l];
			csum[l] = {{2{a_s1[l][31]}}, a_s1[l]}
				+ {d_s1[l][32], d_s1[l][32], d_s1[l][32:1]};
			if (csum[l][33:31] == 3'b000 || csum[l][33:31] == 3'b111) begin
				csat[l] = csum[l][31:0];
			end else if (csum[l][33]) begin
				csat[l] = 32'h8000_0000;
			end else begin
				csat[l] = 32'h7FFF_FFFF;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < ssc_pkg::AXES; l++) begin
				side_s2.neg[l]     <= d_s1[l][32];
				side_s2.mag[l]     <= dabs[l][31:0];
				side_s2.contact[l] <= csat[l];
			end
			side_s2.rsum <= rsum_s1;
		end
	end

	// Stage 3: square each magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < ssc_pkg::AXES; l++) begin
				sq_s3[l] <= side_s2.mag[l] * side_s2.mag[l];
			end
			side_s3 <= side_s2;
		end
	end

	// Stage 4: sum of squares
	always_ff @(posedge clk) begin
		if (en) begin
			sq_s4 <= ssc_pkg::SQ_W'(sq_s3[0]) + ssc_pkg::SQ_W'(sq_s3[1])
				+ ssc_pkg::SQ_W'(sq_s3[2]);
			side_s4 <= side_s3;
		end
	end

	assign out_valid = v_s4;
	assign sq        = sq_s4;
	assign side      = side_s4;

endmodule

FILE: rtl/ssc_sqrt.sv
// Pipelined floor square root, one root bit per stage.
module ssc_sqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [ssc_pkg::SQ_W-1:0]     rad,
	input  ssc_pkg::side_t               side_in,
	output logic                         out_valid,
	output logic [ssc_pkg::ROOT_W-1:0]   root,
	output ssc_pkg::side_t               side_out
);

	localparam int N = ssc_pkg::ROOT_W;

	logic                         v_s    [N];
	logic [ssc_pkg::REM_W-1:0]    rem_s  [N];
	logic [N-1:0]                 root_s [N];
	logic [ssc_pkg::SQ_W-1:0]     rad_s  [N];
	ssc_pkg::side_t               side_s [N];

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic                      v_p;
		logic [ssc_pkg::REM_W-1:0] rem_p;
		logic [N-1:0]              root_p;
		logic [ssc_pkg::SQ_W-1:0]  rad_p;
		ssc_pkg::side_t            side_p;
		logic [ssc_pkg::REM_W+1:0] rem_sh;
		logic [ssc_pkg::REM_W+1:0] trial;
		logic                      ge;

		if (i == 0) begin : g_first
			assign v_p    = in_valid;
			assign rem_p  = '0;
			assign root_p = '0;
			assign rad_p  = rad;
			assign side_p = side_in;
		end else begin : g_next
			assign v_p    = v_s[i-1];
			assign rem_p  = rem_s[i-1];
			assign root_p = root_s[i-1];
			assign rad_p  = rad_s[i-1];
			assign side_p = side_s[i-1];
		end

		// Bring down the next pair of radicand bits and try root*4+1
		assign rem_sh = {rem_p, rad_p[ssc_pkg::SQ_W-1-2*i -: 2]};
		assign trial  = {2'b00, root_p, 2'b01};
		assign ge     = rem_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= ge ? ssc_pkg::REM_W'(rem_sh - trial)
					: ssc_pkg::REM_W'(rem_sh);
				root_s[i] <= {root_p[N-2:0], ge};
				rad_s[i]  <= rad_p;
				side_s[i] <= side_p;
			end
		end
	end

	assign out_valid = v_s[N-1];
	assign root      = root_s[N-1];
	assign side_out  = side_s[N-1];

endmodule

FILE: rtl/ssc_div.sv
// Pipelined restoring divider for the three normal components, one bit per stage.
module ssc_div (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     en,
	input  logic                                     in_valid,
	input  logic [ssc_pkg::AXES-1:0][ssc_pkg::MAG_W-1:0] mag,
	input  ssc_pkg::hit_t                            info_in,
	output logic                                     out_valid,
	output logic [ssc_pkg::AXES-1:0][ssc_pkg::Q_W-1:0]   quo,
	output ssc_pkg::hit_t                            info_out
);

	localparam int N = ssc_pkg::Q_W;

	logic                                     v_s    [N];
	logic [ssc_pkg::AXES-1:0][31:0]           rem_s  [N];
	logic [ssc_pkg::AXES-1:0][N-1:0]          q_s    [N];
	logic [ssc_pkg::AXES-1:0]                 bit0_s [N];
	ssc_pkg::hit_t                            info_s [N];

	for (genvar j = 0; j < N; j++) begin : g_stage
		logic                            v_p;
		logic [ssc_pkg::AXES-1:0][31:0]  rem_p;
		logic [ssc_pkg::AXES-1:0][N-1:0] q_p;
		logic [ssc_pkg::AXES-1:0]        bit_p;
		logic [ssc_pkg::AXES-1:0]        bit0_p;
		ssc_pkg::hit_t                   info_p;
		logic [ssc_pkg::AXES-1:0][32:0]  sh;
		logic [ssc_pkg::AXES-1:0]        ge;

		if (j == 0) begin : g_first
			// Numerator is mag * 2^30: top bits start the remainder
			always_comb begin
				for (int l = 0; l < ssc_pkg::AXES; l++) begin
					rem_p[l]  = {1'b0, mag[l][31:1]};
					bit_p[l]  = mag[l][0];
					bit0_p[l] = 1'b0;
				end
			end
			assign v_p    = in_valid;
			assign q_p    = '0;
			assign info_p = info_in;
		end else begin : g_next
			assign v_p    = v_s[j-1];
			assign rem_p  = rem_s[j-1];
			assign q_p    = q_s[j-1];
			assign bit_p  = bit0_s[j-1];
			assign bit0_p = bit0_s[j-1];
			assign info_p = info_s[j-1];
		end

		// Shift in the next numerator bit and subtract the length if it fits
		always_comb begin
			for (int l = 0; l < ssc_pkg::AXES; l++) begin
				sh[l] = {rem_p[l], bit_p[l]};
				ge[l] = sh[l] >= {1'b0, info_p.len};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (en) begin
				v_s[j] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < ssc_pkg::AXES; l++) begin
					rem_s[j][l] <= ge[l] ? 32'(sh[l] - {1'b0, info_p.len}) : sh[l][31:0];
					q_s[j][l]   <= {q_p[l][N-2:0], ge[l]};
				end
				bit0_s[j] <= bit0_p;
				info_s[j] <= info_p;
			end
		end
	end

	assign out_valid = v_s[N-1];
	assign quo       = q_s[N-1];
	assign info_out  = info_s[N-1];

endmodule
